// ===== rtl/point_to_segment_distance_3d_macros.svh =====
// assertion macros for the point to segment distance block
`ifndef POINT_TO_SEGMENT_DISTANCE_3D_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_3D_MACROS_SVH

// same cycle implication, clocked on clk_i, off during reset
`define P2SD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("p2sd assertion failed");

// next cycle implication, clocked on clk_i, off during reset
`define P2SD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("p2sd assertion failed");

`endif

// ===== rtl/p2sd_pkg.sv =====
// types and constants for the point to segment distance block
package p2sd_pkg;

  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned NumCfg      = 6;
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam logic [CfgIdxWidth-1:0] CfgStartX = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgStartY = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgStartZ = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgEndX   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgEndY   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgEndZ   = 3'd5;

  localparam logic [1:0] RegionStart    = 2'd0;
  localparam logic [1:0] RegionInterior = 2'd1;
  localparam logic [1:0] RegionEnd      = 2'd2;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } query_t;

  typedef struct packed {
    coord_t                  nearest_x;
    coord_t                  nearest_y;
    coord_t                  nearest_z;
    logic [CoordWidth-1:0]   distance;
    logic [1:0]              region;
    logic                    distance_saturated;
  } result_t;

endpackage

// ===== rtl/point_to_segment_distance_3d.sv =====
// closest point on a 3d segment and distance to it, fully pipelined
// One transaction enters per cycle while in_stall_o is low. The depth is set by the two
// bit-per-stage units: a 33-stage restoring divider that places the interior point and a
// 33-stage square root for the distance, plus the product, sum and rounding stages around
// them. The user must write the segment endpoints through the configuration port only
// while no transaction is in flight; the block does not enforce this. A two-entry output
// (result register plus skid register) lets the pipeline keep running while one result
// waits.
`include "point_to_segment_distance_3d_macros.svh"

module point_to_segment_distance_3d (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  p2sd_pkg::query_t                         in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output p2sd_pkg::result_t                        out_data_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [p2sd_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  p2sd_pkg::coord_t                         cfg_data_i
);

  localparam int CW = p2sd_pkg::CoordWidth;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int LW = PW;
  localparam int RW = SW + 2;
  localparam int QW = DW + 1;
  localparam int NW = DW + 2;
  localparam int SQ = DW;
  localparam int XW = PW + 2;

  p2sd_pkg::coord_t cfg_q [p2sd_pkg::NumCfg];
  logic             en;
  logic signed [CW-1:0] qin [3];

  // front stages
  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] w1_q [3];
  logic signed [CW-1:0] x1_q [3];
  logic signed [PW-1:0] pdv2_q [3];
  logic signed [PW-1:0] pdd2_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [CW-1:0] x2_q [3];
  logic signed [SW-1:0] dot3_q;
  logic [LW-1:0]        len3_q;
  logic signed [DW-1:0] d3_q [3];
  logic signed [CW-1:0] x3_q [3];

  // divider stages
  logic                 dv_v_q   [DW+1];
  logic                 dv_v_d   [DW+1];
  logic [1:0]           dv_reg_q [DW+1];
  logic [1:0]           dv_reg_d [DW+1];
  logic [SW-1:0]        dv_b_q [DW+1];
  logic [SW-1:0]        dv_b_d [DW+1];
  logic [SW-1:0]        dv_m_q [DW+1];
  logic [SW-1:0]        dv_m_d [DW+1];
  logic [SW-1:0]        dv_c_q [DW+1];
  logic [SW-1:0]        dv_c_d [DW+1];
  logic [DW-1:0]        dv_a_q [DW+1][3];
  logic [DW-1:0]        dv_a_d [DW+1][3];
  logic                 dv_neg_q [DW+1][3];
  logic                 dv_neg_d [DW+1][3];
  logic [SW-1:0]        dv_r_q [DW+1][3];
  logic [SW-1:0]        dv_r_d [DW+1][3];
  logic [QW-1:0]        dv_qa_q [DW+1][3];
  logic [QW-1:0]        dv_qa_d [DW+1][3];
  logic signed [CW-1:0] dv_x_q [DW+1][3];
  logic signed [CW-1:0] dv_x_d [DW+1][3];

  // nearest point and distance stages
  logic                 v5_q, v6_q, v7_q;
  logic [1:0]           reg5_q, reg6_q, reg7_q;
  logic signed [CW-1:0] n5_q [3];
  logic signed [CW-1:0] x5_q [3];
  logic signed [CW-1:0] n6_q [3];
  logic signed [DW-1:0] e6_q [3];
  logic signed [CW-1:0] n7_q [3];
  logic signed [PW-1:0] sq7_q [3];
  logic signed [CW-1:0] n5_d [3];

  // square root stages
  logic                 sr_v_q [SQ+1];
  logic                 sr_v_d [SQ+1];
  logic [1:0]           sr_reg_q [SQ+1];
  logic [1:0]           sr_reg_d [SQ+1];
  logic [XW-1:0]        sr_rem_q [SQ+1];
  logic [XW-1:0]        sr_rem_d [SQ+1];
  logic [SQ-1:0]        sr_root_q [SQ+1];
  logic [SQ-1:0]        sr_root_d [SQ+1];
  logic signed [CW-1:0] sr_n_q [SQ+1][3];
  logic signed [CW-1:0] sr_n_d [SQ+1][3];

  // final stage and output buffering
  logic                 fin_v_q;
  p2sd_pkg::result_t    fin_d, fin_q;
  logic [SQ:0]          dist_rnd;
  logic                 out_v_q, skid_v_q;
  p2sd_pkg::result_t    out_q, skid_q;
  logic                 hold, arrive, load_skid, load_from_skid, load_from_fin;
  logic                 at_start_pt, at_end_pt;

  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign qin[0] = in_data_i.query_x;
  assign qin[1] = in_data_i.query_y;
  assign qin[2] = in_data_i.query_z;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < p2sd_pkg::NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < p2sd_pkg::CfgIdxWidth'(p2sd_pkg::NumCfg))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // divider: stage 0 classifies, each later stage takes one bit of |d|
  always_comb begin
    logic [RW-1:0] t;
    logic [1:0]    dig;
    dv_v_d[0] = v3_q;
    dv_b_d[0] = $unsigned(dot3_q) << 1;
    dv_m_d[0] = SW'(len3_q) << 1;
    dv_c_d[0] = SW'(len3_q);
    if ((len3_q == '0) || (dot3_q <= 0)) begin
      dv_reg_d[0] = p2sd_pkg::RegionStart;
    end else if ($unsigned(dot3_q) >= SW'(len3_q)) begin
      dv_reg_d[0] = p2sd_pkg::RegionEnd;
    end else begin
      dv_reg_d[0] = p2sd_pkg::RegionInterior;
    end
    for (int i = 0; i < 3; i++) begin
      dv_neg_d[0][i] = d3_q[i][DW-1];
      dv_a_d[0][i]   = d3_q[i][DW-1] ? DW'(-d3_q[i]) : DW'(d3_q[i]);
      dv_r_d[0][i]   = '0;
      dv_qa_d[0][i]  = '0;
      dv_x_d[0][i]   = x3_q[i];
    end
    for (int k = 0; k < DW; k++) begin
      dv_v_d[k+1]   = dv_v_q[k];
      dv_reg_d[k+1] = dv_reg_q[k];
      dv_b_d[k+1]   = dv_b_q[k];
      dv_m_d[k+1]   = dv_m_q[k];
      dv_c_d[k+1]   = dv_c_q[k];
      for (int i = 0; i < 3; i++) begin
        t = RW'(dv_r_q[k][i]) << 1;
        if (dv_a_q[k][i][DW-1-k]) begin
          t = t + RW'(dv_b_q[k]);
        end
        if (t >= (RW'(dv_m_q[k]) << 1)) begin
          t   = t - (RW'(dv_m_q[k]) << 1);
          dig = 2'd2;
        end else if (t >= RW'(dv_m_q[k])) begin
          t   = t - RW'(dv_m_q[k]);
          dig = 2'd1;
        end else begin
          dig = 2'd0;
        end
        dv_r_d[k+1][i]   = t[SW-1:0];
        dv_qa_d[k+1][i]  = (dv_qa_q[k][i] << 1) + QW'(dig);
        dv_a_d[k+1][i]   = dv_a_q[k][i];
        dv_neg_d[k+1][i] = dv_neg_q[k][i];
        dv_x_d[k+1][i]   = dv_x_q[k][i];
      end
    end
  end

  // nearest point: final rounding of the quotient and region select
  always_comb begin
    logic [QW-1:0]        off;
    logic signed [NW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      off = dv_qa_q[DW][i] + QW'((RW'(dv_r_q[DW][i]) + RW'(dv_c_q[DW])) >= RW'(dv_m_q[DW]));
      if (dv_neg_q[DW][i]) begin
        sum = NW'(cfg_q[i]) - $signed(NW'(off));
      end else begin
        sum = NW'(cfg_q[i]) + $signed(NW'(off));
      end
      case (dv_reg_q[DW])
        p2sd_pkg::RegionStart:    n5_d[i] = cfg_q[i];
        p2sd_pkg::RegionEnd:      n5_d[i] = cfg_q[3+i];
        p2sd_pkg::RegionInterior: n5_d[i] = sum[CW-1:0];
        default:                  n5_d[i] = cfg_q[i];
      endcase
    end
  end

  // square root: one result bit per stage
  always_comb begin
    logic [XW-1:0] trial;
    int            b;
    sr_v_d[0]    = v7_q;
    sr_reg_d[0]  = reg7_q;
    sr_root_d[0] = '0;
    sr_rem_d[0]  = XW'($unsigned(sq7_q[0])) + XW'($unsigned(sq7_q[1]))
                 + XW'($unsigned(sq7_q[2]));
    for (int i = 0; i < 3; i++) begin
      sr_n_d[0][i] = n7_q[i];
    end
    for (int j = 0; j < SQ; j++) begin
      b = SQ - 1 - j;
      trial = (XW'(sr_root_q[j]) << (b + 1)) | (XW'(1) << (2 * b));
      sr_v_d[j+1]   = sr_v_q[j];
      sr_reg_d[j+1] = sr_reg_q[j];
      if (sr_rem_q[j] >= trial) begin
        sr_rem_d[j+1]  = sr_rem_q[j] - trial;
        sr_root_d[j+1] = sr_root_q[j] | (SQ'(1) << b);
      end else begin
        sr_rem_d[j+1]  = sr_rem_q[j];
        sr_root_d[j+1] = sr_root_q[j];
      end
      for (int i = 0; i < 3; i++) begin
        sr_n_d[j+1][i] = sr_n_q[j][i];
      end
    end
  end

  // round to nearest and saturate
  always_comb begin
    dist_rnd = (SQ+1)'(sr_root_q[SQ]) + (SQ+1)'(sr_rem_q[SQ] > XW'(sr_root_q[SQ]));
    fin_d.nearest_x          = sr_n_q[SQ][0];
    fin_d.nearest_y          = sr_n_q[SQ][1];
    fin_d.nearest_z          = sr_n_q[SQ][2];
    fin_d.region             = sr_reg_q[SQ];
    fin_d.distance_saturated = |dist_rnd[SQ:CW];
    fin_d.distance           = (|dist_rnd[SQ:CW]) ? '1 : dist_rnd[CW-1:0];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      fin_v_q <= 1'b0;
      for (int k = 0; k <= DW; k++) begin
        dv_v_q[k] <= 1'b0;
      end
      for (int j = 0; j <= SQ; j++) begin
        sr_v_q[j] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v5_q    <= dv_v_q[DW];
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      fin_v_q <= sr_v_q[SQ];
      for (int k = 0; k <= DW; k++) begin
        dv_v_q[k] <= dv_v_d[k];
      end
      for (int j = 0; j <= SQ; j++) begin
        sr_v_q[j] <= sr_v_d[j];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]   <= DW'(cfg_q[3+i]) - DW'(cfg_q[i]);
        w1_q[i]   <= DW'(qin[i]) - DW'(cfg_q[i]);
        x1_q[i]   <= qin[i];
        pdv2_q[i] <= PW'(d1_q[i]) * PW'(w1_q[i]);
        pdd2_q[i] <= PW'(d1_q[i]) * PW'(d1_q[i]);
        d2_q[i]   <= d1_q[i];
        x2_q[i]   <= x1_q[i];
        d3_q[i]   <= d2_q[i];
        x3_q[i]   <= x2_q[i];
        n5_q[i]   <= n5_d[i];
        x5_q[i]   <= dv_x_q[DW][i];
        n6_q[i]   <= n5_q[i];
        e6_q[i]   <= DW'(x5_q[i]) - DW'(n5_q[i]);
        n7_q[i]   <= n6_q[i];
        sq7_q[i]  <= PW'(e6_q[i]) * PW'(e6_q[i]);
      end
      dot3_q <= SW'(pdv2_q[0]) + SW'(pdv2_q[1]) + SW'(pdv2_q[2]);
      len3_q <= LW'($unsigned(pdd2_q[0])) + LW'($unsigned(pdd2_q[1]))
              + LW'($unsigned(pdd2_q[2]));
      reg5_q <= dv_reg_q[DW];
      reg6_q <= reg5_q;
      reg7_q <= reg6_q;
      for (int k = 0; k <= DW; k++) begin
        dv_reg_q[k] <= dv_reg_d[k];
        dv_b_q[k]   <= dv_b_d[k];
        dv_m_q[k]   <= dv_m_d[k];
        dv_c_q[k]   <= dv_c_d[k];
        for (int i = 0; i < 3; i++) begin
          dv_a_q[k][i]   <= dv_a_d[k][i];
          dv_neg_q[k][i] <= dv_neg_d[k][i];
          dv_r_q[k][i]   <= dv_r_d[k][i];
          dv_qa_q[k][i]  <= dv_qa_d[k][i];
          dv_x_q[k][i]   <= dv_x_d[k][i];
        end
      end
      for (int j = 0; j <= SQ; j++) begin
        sr_reg_q[j]  <= sr_reg_d[j];
        sr_rem_q[j]  <= sr_rem_d[j];
        sr_root_q[j] <= sr_root_d[j];
        for (int i = 0; i < 3; i++) begin
          sr_n_q[j][i] <= sr_n_d[j][i];
        end
      end
      fin_q <= fin_d;
    end
  end

  // output register with skid
  assign hold           = out_v_q && out_stall_i;
  assign arrive         = en && fin_v_q;
  assign load_skid      = hold && arrive;
  assign load_from_skid = !hold && skid_v_q;
  assign load_from_fin  = !hold && !skid_v_q && arrive;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (hold) begin
      if (load_skid) begin
        skid_v_q <= 1'b1;
      end
    end else begin
      out_v_q  <= skid_v_q || arrive;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_skid) begin
      skid_q <= fin_q;
    end
    if (load_from_skid) begin
      out_q <= skid_q;
    end else if (load_from_fin) begin
      out_q <= fin_q;
    end
  end

  assign at_start_pt = (out_q.nearest_x == cfg_q[p2sd_pkg::CfgStartX])
                    && (out_q.nearest_y == cfg_q[p2sd_pkg::CfgStartY])
                    && (out_q.nearest_z == cfg_q[p2sd_pkg::CfgStartZ]);
  assign at_end_pt   = (out_q.nearest_x == cfg_q[p2sd_pkg::CfgEndX])
                    && (out_q.nearest_y == cfg_q[p2sd_pkg::CfgEndY])
                    && (out_q.nearest_z == cfg_q[p2sd_pkg::CfgEndZ]);

  `P2SD_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q)
  `P2SD_ASSERT_NXT(a_skid_catch, load_skid, skid_v_q && out_v_q)
  `P2SD_ASSERT_IMP(a_start_point, out_v_q && (out_q.region == p2sd_pkg::RegionStart), at_start_pt)
  `P2SD_ASSERT_IMP(a_end_point, out_v_q && (out_q.region == p2sd_pkg::RegionEnd), at_end_pt)
  `P2SD_ASSERT_IMP(a_sat_max, out_v_q && out_q.distance_saturated, &out_q.distance)

endmodule
